// ----- design/ltl_pkg.sv -----
package ltl_pkg;

  localparam int DEF_POS_BITS = 32;
  localparam int DEF_LEN_BITS = 16;
  localparam int KIND_W       = 4;
  localparam int Q_DEPTH      = 4;

  typedef enum logic [KIND_W-1:0] {
    K_WS      = 4'd0,
    K_STRING  = 4'd1,
    K_COMMENT = 4'd2,
    K_DOT     = 4'd3,
    K_NUMBER  = 4'd4,
    K_IDENT   = 4'd5,
    K_QUOTE   = 4'd6,
    K_LPAREN  = 4'd7,
    K_RPAREN  = 4'd8,
    K_UNKNOWN = 4'd9,
    K_EOF     = 4'd10
  } kind_t;

  // Running check of the number syntax: [-] digits+ or [-] digits* / digits+
  typedef enum logic [2:0] {
    N_START = 3'd0,
    N_SIGN  = 3'd1,
    N_INT   = 3'd2,
    N_SLASH = 3'd3,
    N_FRAC  = 3'd4,
    N_BAD   = 3'd5
  } num_t;

  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic num_t num_next(input num_t s, input logic [7:0] c);
    num_t r;
    r = N_BAD;
    case (s)
      N_START: begin
        if (c == CH_MINUS) r = N_SIGN;
        else if (is_digit(c)) r = N_INT;
        else if (c == CH_SLASH) r = N_SLASH;
      end
      N_SIGN, N_INT: begin
        if (is_digit(c)) r = N_INT;
        else if (c == CH_SLASH) r = N_SLASH;
      end
      N_SLASH, N_FRAC: begin
        if (is_digit(c)) r = N_FRAC;
      end
      default: r = N_BAD;
    endcase
    return r;
  endfunction

endpackage

// ----- design/lisp_token_lexer_core.sv -----
// Channel  | Handshake                      | Payload
// ---------+--------------------------------+---------------------------------------------
// input    | push / full, taken on push&!full | in_ch, in_end_of_input
// result   | empty / pop, taken on pop&!empty | out_kind, out_start_res, out_length, out_last
//
// The lexer front takes one transaction a cycle while its queue has room; it
// classifies the character combinationally and writes any results to the queue.
// A result passes from its queue entry into the output register, where it waits for pop.
// An item that closes two tokens yields two results, shown one after the other.
// Synchronous active-low reset returns the lexer to the start of a stream and
// empties the queue and output register; no clearing pass is needed.
// A stalled result side fills the queue (depth Q_DEPTH), then full rises.
module lisp_token_lexer_core #(
  parameter int POS_BITS = ltl_pkg::DEF_POS_BITS,
  parameter int LEN_BITS = ltl_pkg::DEF_LEN_BITS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  output logic                       full,
  input  logic [7:0]                 in_ch,
  input  logic                       in_end_of_input,
  output logic                       empty,
  input  logic                       pop,
  output logic [ltl_pkg::KIND_W-1:0] out_kind,
  output logic [POS_BITS-1:0]        out_start_res,
  output logic [LEN_BITS-1:0]        out_length,
  output logic                       out_last
);
  import ltl_pkg::*;

  localparam int RES_W   = KIND_W + POS_BITS + LEN_BITS;
  localparam int ENTRY_W = 1 + 2 * RES_W;

  logic                acc;
  logic                res_v, two;
  kind_t               k0, k1;
  logic [POS_BITS-1:0] s0, s1;
  logic [LEN_BITS-1:0] l0, l1;
  logic [ENTRY_W-1:0]  q_wdata, q_rdata;
  logic                q_full, q_empty, q_rd;

  // Take a transaction whenever the queue can hold what it may produce
  assign full = q_full;
  assign acc  = push && !q_full;

  ltl_front #(
    .POS_BITS (POS_BITS),
    .LEN_BITS (LEN_BITS)
  ) u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .acc   (acc),
    .ch    (in_ch),
    .eoi   (in_end_of_input),
    .res_v (res_v),
    .two   (two),
    .k0    (k0),
    .s0    (s0),
    .l0    (l0),
    .k1    (k1),
    .s1    (s1),
    .l1    (l1)
  );

  // Pack both results of one item into a single queue entry; drop items with none
  assign q_wdata = {two, k1, s1, l1, k0, s0, l0};

  ltl_fifo #(
    .WIDTH (ENTRY_W)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (acc && res_v),
    .wdata (q_wdata),
    .rd    (q_rd),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  ltl_back #(
    .POS_BITS (POS_BITS),
    .LEN_BITS (LEN_BITS),
    .ENTRY_W  (ENTRY_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (q_rdata),
    .q_rd      (q_rd),
    .empty     (empty),
    .pop       (pop),
    .kind      (out_kind),
    .start_res (out_start_res),
    .length    (out_length),
    .last      (out_last)
  );

endmodule

// ----- design/ltl_front.sv -----
module ltl_front #(
  parameter int POS_BITS = ltl_pkg::DEF_POS_BITS,
  parameter int LEN_BITS = ltl_pkg::DEF_LEN_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                acc,
  input  logic [7:0]          ch,
  input  logic                eoi,
  output logic                res_v,
  output logic                two,
  output ltl_pkg::kind_t      k0,
  output logic [POS_BITS-1:0] s0,
  output logic [LEN_BITS-1:0] l0,
  output ltl_pkg::kind_t      k1,
  output logic [POS_BITS-1:0] s1,
  output logic [LEN_BITS-1:0] l1
);
  import ltl_pkg::*;

  typedef enum logic [2:0] {
    M_IDLE    = 3'd0,
    M_WS      = 3'd1,
    M_STR     = 3'd2,
    M_ESC     = 3'd3,
    M_IDENT   = 3'd4,
    M_COMMENT = 3'd5
  } mode_t;

  mode_t               mode_r, mode_nxt;
  num_t                nc_r, nc_nxt;
  logic                semi_r, semi_nxt;
  logic                dot_r, dot_nxt;
  logic [POS_BITS-1:0] start_r, start_nxt;
  logic [LEN_BITS-1:0] len_r, len_nxt;
  logic [POS_BITS-1:0] pos_r, pos_nxt;

  logic [LEN_BITS-1:0] len_grow;
  kind_t               ident_k;
  logic                do_idle;
  logic                cls_v, sec_v;
  kind_t               cls_k, sec_k;
  logic [POS_BITS-1:0] cls_s, sec_s;
  logic [LEN_BITS-1:0] cls_l, sec_l;

  assign len_grow = (len_r == '1) ? len_r : len_r + LEN_BITS'(1);

  always_comb begin
    if (dot_r && (len_r == LEN_BITS'(1))) ident_k = K_DOT;
    else if ((nc_r == N_INT) || (nc_r == N_FRAC)) ident_k = K_NUMBER;
    else ident_k = K_IDENT;
  end

  always_comb begin
    mode_nxt  = mode_r;
    nc_nxt    = nc_r;
    semi_nxt  = semi_r;
    dot_nxt   = dot_r;
    start_nxt = start_r;
    len_nxt   = len_r;
    pos_nxt   = pos_r + POS_BITS'(1);
    do_idle   = 1'b0;
    cls_v     = 1'b0;
    cls_k     = K_WS;
    cls_s     = start_r;
    cls_l     = len_r;
    sec_v     = 1'b0;
    sec_k     = K_EOF;
    sec_s     = pos_r;
    sec_l     = '0;

    if (eoi) begin
      case (mode_r)
        M_WS: begin
          cls_v = 1'b1;
          cls_k = K_WS;
        end
        M_STR, M_ESC: begin
          cls_v = 1'b1;
          cls_k = K_UNKNOWN;
          cls_l = '0;
        end
        M_IDENT: begin
          cls_v = 1'b1;
          cls_k = ident_k;
        end
        M_COMMENT: begin
          cls_v = 1'b1;
          cls_k = K_COMMENT;
        end
        default: cls_v = 1'b0;
      endcase
      sec_v     = 1'b1;
      mode_nxt  = M_IDLE;
      nc_nxt    = N_START;
      semi_nxt  = 1'b0;
      dot_nxt   = 1'b0;
      start_nxt = '0;
      len_nxt   = '0;
      pos_nxt   = '0;
    end else begin
      case (mode_r)
        M_WS: begin
          if (is_ws(ch)) begin
            len_nxt = len_grow;
          end else begin
            cls_v   = 1'b1;
            cls_k   = K_WS;
            do_idle = 1'b1;
          end
        end
        M_STR: begin
          len_nxt = len_grow;
          if (ch == CH_DQUOTE) begin
            cls_v    = 1'b1;
            cls_k    = K_STRING;
            cls_l    = len_grow;
            mode_nxt = M_IDLE;
          end else if (ch == CH_BSLASH) begin
            mode_nxt = M_ESC;
          end
        end
        M_ESC: begin
          len_nxt  = len_grow;
          mode_nxt = M_STR;
        end
        M_IDENT: begin
          if (is_ws(ch) || (ch == CH_RPAREN)) begin
            cls_v   = 1'b1;
            cls_k   = ident_k;
            do_idle = 1'b1;
          end else if ((len_r == LEN_BITS'(1)) && semi_r && (ch == CH_SEMI)) begin
            len_nxt  = len_grow;
            mode_nxt = M_COMMENT;
          end else begin
            len_nxt = len_grow;
            nc_nxt  = num_next(nc_r, ch);
          end
        end
        M_COMMENT: begin
          if ((ch == CH_LF) || (ch == CH_CR)) begin
            cls_v   = 1'b1;
            cls_k   = K_COMMENT;
            do_idle = 1'b1;
          end else begin
            len_nxt = len_grow;
          end
        end
        default: do_idle = 1'b1;
      endcase

      // In idle or after a closing char, start a token with this char
      if (do_idle) begin
        mode_nxt = M_IDLE;
        sec_s    = pos_r;
        sec_l    = LEN_BITS'(1);
        if (is_ws(ch)) begin
          mode_nxt  = M_WS;
          start_nxt = pos_r;
          len_nxt   = LEN_BITS'(1);
        end else if (ch == CH_QUOTE) begin
          sec_v = 1'b1;
          sec_k = K_QUOTE;
        end else if (ch == CH_LPAREN) begin
          sec_v = 1'b1;
          sec_k = K_LPAREN;
        end else if (ch == CH_RPAREN) begin
          sec_v = 1'b1;
          sec_k = K_RPAREN;
        end else if (ch == CH_DQUOTE) begin
          mode_nxt  = M_STR;
          start_nxt = pos_r;
          len_nxt   = LEN_BITS'(1);
        end else begin
          mode_nxt  = M_IDENT;
          start_nxt = pos_r;
          len_nxt   = LEN_BITS'(1);
          nc_nxt    = num_next(N_START, ch);
          semi_nxt  = (ch == CH_SEMI);
          dot_nxt   = (ch == CH_DOT);
        end
      end
    end
  end

  assign res_v = cls_v | sec_v;
  assign two   = cls_v & sec_v;
  assign k0    = cls_v ? cls_k : sec_k;
  assign s0    = cls_v ? cls_s : sec_s;
  assign l0    = cls_v ? cls_l : sec_l;
  assign k1    = sec_k;
  assign s1    = sec_s;
  assign l1    = sec_l;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= M_IDLE;
      nc_r    <= N_START;
      semi_r  <= 1'b0;
      dot_r   <= 1'b0;
      start_r <= '0;
      len_r   <= '0;
      pos_r   <= '0;
    end else if (acc) begin
      mode_r  <= mode_nxt;
      nc_r    <= nc_nxt;
      semi_r  <= semi_nxt;
      dot_r   <= dot_nxt;
      start_r <= start_nxt;
      len_r   <= len_nxt;
      pos_r   <= pos_nxt;
    end
  end

endmodule

// ----- design/ltl_fifo.sv -----
module ltl_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             rd,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);
  import ltl_pkg::*;

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  logic [WIDTH-1:0] mem [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_wr, do_rd;

  assign full  = (count_r == CNT_W'(Q_DEPTH));
  assign empty = (count_r == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = mem[rd_ptr_r];

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(Q_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (do_wr) mem[wr_ptr_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (do_rd) rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (do_wr && !do_rd) count_r <= count_r + CNT_W'(1);
      else if (do_rd && !do_wr) count_r <= count_r - CNT_W'(1);
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(Q_DEPTH))
    else $error("queue count beyond depth");
`endif

endmodule

// ----- design/ltl_back.sv -----
module ltl_back #(
  parameter int POS_BITS = ltl_pkg::DEF_POS_BITS,
  parameter int LEN_BITS = ltl_pkg::DEF_LEN_BITS,
  parameter int ENTRY_W  = 1 + 2 * (ltl_pkg::KIND_W + POS_BITS + LEN_BITS)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_empty,
  input  logic [ENTRY_W-1:0]        q_data,
  output logic                      q_rd,
  output logic                      empty,
  input  logic                      pop,
  output logic [ltl_pkg::KIND_W-1:0] kind,
  output logic [POS_BITS-1:0]       start_res,
  output logic [LEN_BITS-1:0]       length,
  output logic                      last
);
  import ltl_pkg::*;

  localparam int RES_W = KIND_W + POS_BITS + LEN_BITS;

  logic [RES_W-1:0]    slot0, slot1, pick;
  logic                two;
  logic                load, take;
  logic                out_v_r, sel_r;
  logic [KIND_W-1:0]   kind_r;
  logic [POS_BITS-1:0] start_r;
  logic [LEN_BITS-1:0] len_r;
  logic                last_r;

  assign slot0 = q_data[RES_W-1:0];
  assign slot1 = q_data[2*RES_W-1:RES_W];
  assign two   = q_data[2*RES_W];
  assign pick  = sel_r ? slot1 : slot0;

  assign take = pop && out_v_r;
  assign load = !q_empty && (!out_v_r || take);
  assign q_rd = load && (sel_r || !two);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      sel_r   <= 1'b0;
    end else begin
      if (load) begin
        out_v_r <= 1'b1;
        sel_r   <= !sel_r && two;
      end else if (take) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      len_r   <= pick[LEN_BITS-1:0];
      start_r <= pick[LEN_BITS +: POS_BITS];
      kind_r  <= pick[LEN_BITS+POS_BITS +: KIND_W];
      last_r  <= sel_r || !two;
    end
  end

  assign empty     = !out_v_r;
  assign kind      = kind_r;
  assign start_res = start_r;
  assign length    = len_r;
  assign last      = last_r;

`ifndef SYNTHESIS
  a_sel_has_pair: assert property (@(posedge clk) disable iff (!rst_n)
    sel_r |-> (!q_empty && two))
    else $error("second half pending without a pair at the queue head");
  a_nonlast_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !last_r) |-> sel_r)
    else $error("first result shown but its partner is not pending");
  a_pop_on_load: assert property (@(posedge clk) disable iff (!rst_n)
    (load && !sel_r && two) |=> (sel_r && out_v_r && !last_r))
    else $error("pair not split into two results");
`endif

endmodule
